>>> rtl/azimuth_harmonic_acn_generator_unit_macros.svh
// Assertion macros shared by the azimuth harmonic generator checkers
`ifndef AZIMUTH_HARMONIC_ACN_GENERATOR_UNIT_MACROS_SVH
`define AZIMUTH_HARMONIC_ACN_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define AHG_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AHG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ahg_pkg.sv
// Shared types, constants and the CORDIC arctangent table
package ahg_pkg;

   localparam int PHI_W        = 16;
   localparam int VAL_W        = 18;
   localparam int ACN_W        = 6;
   localparam int ORD_REG_W    = 3;
   localparam int ITER_W       = 5;
   localparam int CORDIC_ITERS = 31;
   localparam int Z_W          = 33;
   localparam int ATAN_W       = 30;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);
   localparam logic signed [PHI_W:0] QUARTER_TURN = 17'sd16384;
   localparam logic signed [PHI_W:0] HALF_TURN    = 17'sd32768;
   localparam logic [ORD_REG_W-1:0] ORDER_RESET   = 3'd1;

   typedef struct packed {
      logic signed [PHI_W-1:0] angle;   // folded into [-quarter, +quarter] turn
      logic                    flip;    // negate cos and sin at the end
      logic [ORD_REG_W-1:0]    order;   // saturated order
   } ahg_job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_SEED,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } ahg_state_type;

   // atan(2^-i) with 2^31 = pi
   function automatic logic [ATAN_W-1:0] atan_lookup(input logic [ITER_W-1:0] idx);
      logic [ATAN_W-1:0] r;
      case (idx)
         5'd0:  r = 30'h20000000;
         5'd1:  r = 30'h12E4051E;
         5'd2:  r = 30'h09FB385B;
         5'd3:  r = 30'h051111D4;
         5'd4:  r = 30'h028B0D43;
         5'd5:  r = 30'h0145D7E1;
         5'd6:  r = 30'h00A2F61E;
         5'd7:  r = 30'h00517C55;
         5'd8:  r = 30'h0028BE53;
         5'd9:  r = 30'h00145F2F;
         5'd10: r = 30'h000A2F98;
         5'd11: r = 30'h000517CC;
         5'd12: r = 30'h00028BE6;
         5'd13: r = 30'h000145F3;
         5'd14: r = 30'h0000A2FA;
         5'd15: r = 30'h0000517D;
         5'd16: r = 30'h000028BE;
         5'd17: r = 30'h0000145F;
         5'd18: r = 30'h00000A30;
         5'd19: r = 30'h00000518;
         5'd20: r = 30'h0000028C;
         5'd21: r = 30'h00000146;
         5'd22: r = 30'h000000A3;
         5'd23: r = 30'h00000051;
         5'd24: r = 30'h00000029;
         5'd25: r = 30'h00000014;
         5'd26: r = 30'h0000000A;
         5'd27: r = 30'h00000005;
         5'd28: r = 30'h00000003;
         5'd29: r = 30'h00000001;
         5'd30: r = 30'h00000001;
         default: r = 30'h00000000;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/ahg_if.sv
// Channel interfaces: angle requests, harmonic responses, order register writes
interface ahg_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ahg_pkg::PHI_W-1:0]    phi;
   modport source (output valid, output phi, input ready);
   modport sink   (input valid, input phi, output ready);
endinterface

interface ahg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ahg_pkg::VAL_W-1:0]    harmonic_value;
   logic [ahg_pkg::ACN_W-1:0]           acn_index;
   logic                                last;
   modport source (output valid, output harmonic_value, output acn_index, output last,
                   input ready);
   modport sink   (input valid, input harmonic_value, input acn_index, input last,
                   output ready);
endinterface

interface ahg_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ahg_pkg::ORD_REG_W-1:0]       order;
   modport source (output valid, output order, input ready);
   modport sink   (input valid, input order, output ready);
endinterface

>>> rtl/ahg_front.sv
// Front end: takes angle transfers, folds the quadrant and saturates the order
module ahg_front #(
   parameter int MAX_ORDER = 7
) (
   ahg_req_if.sink                       req,
   input  logic [ahg_pkg::ORD_REG_W-1:0] order_val,
   output logic                          push_valid,
   input  logic                          push_ready,
   output ahg_pkg::ahg_job_type          push_data
);

   logic signed [ahg_pkg::PHI_W:0] phi_ext;
   logic signed [ahg_pkg::PHI_W:0] phi_fold;
   logic                           flip;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   always_comb begin
      phi_ext  = (ahg_pkg::PHI_W + 1)'(req.phi);
      phi_fold = phi_ext;
      flip     = 1'b0;
      if (phi_ext > ahg_pkg::QUARTER_TURN) begin
         phi_fold = phi_ext - ahg_pkg::HALF_TURN;
         flip     = 1'b1;
      end else if (phi_ext < -ahg_pkg::QUARTER_TURN) begin
         phi_fold = phi_ext + ahg_pkg::HALF_TURN;
         flip     = 1'b1;
      end
   end

   always_comb begin
      push_data.angle = phi_fold[ahg_pkg::PHI_W-1:0];
      push_data.flip  = flip;
      if (order_val > ahg_pkg::ORD_REG_W'(MAX_ORDER)) begin
         push_data.order = ahg_pkg::ORD_REG_W'(MAX_ORDER);
      end else begin
         push_data.order = order_val;
      end
   end

endmodule

>>> rtl/ahg_queue.sv
// Two-entry job queue between front end and harmonic engine
module ahg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  ahg_pkg::ahg_job_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output ahg_pkg::ahg_job_type pop_data
);

   localparam int PTR_W = $clog2(ahg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ahg_pkg::QUEUE_DEPTH + 1);

   ahg_pkg::ahg_job_type mem_ff [ahg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(ahg_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ahg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ahg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/ahg_back.sv
// Harmonic engine: iterative CORDIC, Chebyshev recursion, ACN-ordered output
module ahg_back #(
   parameter int MAX_ORDER = 7,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  ahg_pkg::ahg_job_type pop_data,
   ahg_rsp_if.source            rsp
);

   localparam int VW     = FRAC_BITS + 2;
   localparam int XW     = FRAC_BITS + 3;
   localparam int MW     = 2 * VW;
   localparam int PW     = MW + 1;
   localparam int SW     = PW + 1;
   localparam int ORD_W  = $clog2(MAX_ORDER + 1);
   localparam int CW     = $clog2(MAX_ORDER + 2);
   localparam int KW     = CW + 1;
   localparam int SH_DN  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam int SH_UP  = (FRAC_BITS > 16) ? 0 : 16 - FRAC_BITS;
   localparam int QW     = VW + SH_UP + 1;
   localparam int TAB_N  = MAX_ORDER + 1;

   localparam logic [63:0] X0_FULL =
      (64'd2608131496 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   localparam logic signed [XW-1:0] X0    = X0_FULL[XW-1:0];
   localparam logic signed [VW-1:0] ONE_V = VW'(64'd1 << FRAC_BITS);
   localparam logic signed [SW-1:0] RND_R = SW'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [QW-1:0] RND_Q = (SH_DN > 0) ? QW'(64'd1 << (SH_DN - 1)) : '0;

   function automatic logic signed [VW-1:0] clamp_x(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] one_x;
      logic signed [VW-1:0] r;
      one_x = XW'(ONE_V);
      if (v > one_x) begin
         r = ONE_V;
      end else if (v < -one_x) begin
         r = -ONE_V;
      end else begin
         r = v[VW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [ahg_pkg::VAL_W-1:0] to_q16(input logic signed [VW-1:0] v);
      logic signed [QW-1:0] t;
      t = QW'(v);
      t = ((t + RND_Q) >>> SH_DN) <<< SH_UP;
      return t[ahg_pkg::VAL_W-1:0];
   endfunction

   ahg_pkg::ahg_state_type state_ff, state_in;

   // CORDIC
   logic signed [XW-1:0]           x_ff, y_ff;
   logic signed [ahg_pkg::Z_W-1:0] z_ff;
   logic [ahg_pkg::ITER_W-1:0]     iter_ff;
   logic                           flip_ff;
   logic [ORD_W-1:0]               ord_ff;
   logic signed [XW-1:0]           x_sh, y_sh, x_in, y_in;
   logic signed [ahg_pkg::Z_W-1:0] z_in, atan_z;
   logic signed [VW-1:0]           xc, yc, cos1, sin1, sn1;

   // recursion
   logic signed [VW-1:0] c1_ff, cp_ff, cp2_ff, sp_ff, sp2_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [MW-1:0] mul_raw;
   logic signed [VW-1:0] mul_b, sub_v, acc_v;
   logic signed [SW-1:0] acc_sum;
   logic                 sel_ff;
   logic [CW-1:0]        step_ff;
   logic [ORD_W-1:0]     step_idx;

   logic signed [ahg_pkg::VAL_W-1:0] cs_tab_ff [TAB_N];
   logic signed [ahg_pkg::VAL_W-1:0] sn_tab_ff [TAB_N];

   // emission
   logic [CW-1:0]                    n_ff;
   logic [KW-1:0]                    k_ff;
   logic [ahg_pkg::ACN_W-1:0]        acn_ff;
   logic                             m_neg, k_end, em_last;
   logic [KW-1:0]                    idx_full;
   logic [ORD_W-1:0]                 idx;
   logic signed [ahg_pkg::VAL_W-1:0] em_value;

   logic                             rsp_valid_ff;
   logic signed [ahg_pkg::VAL_W-1:0] rsp_value_ff;
   logic [ahg_pkg::ACN_W-1:0]        rsp_acn_ff;
   logic                             rsp_last_ff;

   logic out_free;
   logic job_take, emit_load, recur_done;

   assign out_free = !rsp_valid_ff || rsp.ready;

   // CORDIC datapath
   always_comb begin
      x_sh   = x_ff >>> iter_ff;
      y_sh   = y_ff >>> iter_ff;
      atan_z = signed'({3'b000, ahg_pkg::atan_lookup(iter_ff)});
      if (!z_ff[ahg_pkg::Z_W-1]) begin
         x_in = x_ff - y_sh;
         y_in = y_ff + x_sh;
         z_in = z_ff - atan_z;
      end else begin
         x_in = x_ff + y_sh;
         y_in = y_ff - x_sh;
         z_in = z_ff + atan_z;
      end
      xc   = clamp_x(x_ff);
      yc   = clamp_x(y_ff);
      cos1 = flip_ff ? -xc : xc;
      sin1 = flip_ff ? -yc : yc;
      sn1  = -sin1;
   end

   // recursion datapath: c(i) = round(2*c1*c(i-1)) - c(i-2), clamped to +-1
   always_comb begin
      mul_b   = sel_ff ? sp_ff : cp_ff;
      mul_raw = c1_ff * mul_b;
      sub_v   = sel_ff ? sp2_ff : cp2_ff;
      acc_sum = ((SW'(prod_ff) + RND_R) >>> FRAC_BITS) - SW'(sub_v);
      if (acc_sum > SW'(ONE_V)) begin
         acc_v = ONE_V;
      end else if (acc_sum < -SW'(ONE_V)) begin
         acc_v = -ONE_V;
      end else begin
         acc_v = acc_sum[VW-1:0];
      end
      step_idx   = step_ff[ORD_W-1:0];
      recur_done = sel_ff && (step_ff == CW'(ord_ff));
   end

   // emission: k = acn - n*n, m = k - n
   always_comb begin
      m_neg    = k_ff < KW'(n_ff);
      idx_full = m_neg ? (KW'(n_ff) - k_ff) : (k_ff - KW'(n_ff));
      idx      = idx_full[ORD_W-1:0];
      em_value = m_neg ? sn_tab_ff[idx] : cs_tab_ff[idx];
      k_end    = k_ff == {n_ff, 1'b0};
      em_last  = k_end && (n_ff == CW'(ord_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ahg_pkg::ST_IDLE: begin
            if (pop_valid) state_in = ahg_pkg::ST_CORDIC;
         end
         ahg_pkg::ST_CORDIC: begin
            if (iter_ff == ahg_pkg::ITER_LAST) state_in = ahg_pkg::ST_SEED;
         end
         ahg_pkg::ST_SEED: begin
            if (CW'(ord_ff) < CW'(2)) begin
               state_in = ahg_pkg::ST_EMIT;
            end else begin
               state_in = ahg_pkg::ST_MUL;
            end
         end
         ahg_pkg::ST_MUL: begin
            state_in = ahg_pkg::ST_ACC;
         end
         ahg_pkg::ST_ACC: begin
            if (recur_done) begin
               state_in = ahg_pkg::ST_EMIT;
            end else begin
               state_in = ahg_pkg::ST_MUL;
            end
         end
         ahg_pkg::ST_EMIT: begin
            if (out_free && em_last) state_in = ahg_pkg::ST_IDLE;
         end
         default: state_in = ahg_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop_ready = 1'b0;
      emit_load = 1'b0;
      unique case (state_ff)
         ahg_pkg::ST_IDLE: pop_ready = 1'b1;
         ahg_pkg::ST_EMIT: emit_load = out_free;
         default: begin
            pop_ready = 1'b0;
            emit_load = 1'b0;
         end
      endcase
   end

   assign job_take = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ahg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         x_ff    <= X0;
         y_ff    <= '0;
         z_ff    <= ahg_pkg::Z_W'(pop_data.angle) <<< 16;
         iter_ff <= '0;
         flip_ff <= pop_data.flip;
         ord_ff  <= pop_data.order[ORD_W-1:0];
      end
      if (state_ff == ahg_pkg::ST_CORDIC) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         iter_ff <= iter_ff + 1'b1;
      end
      if (state_ff == ahg_pkg::ST_SEED) begin
         c1_ff   <= cos1;
         cp_ff   <= cos1;
         cp2_ff  <= ONE_V;
         sp_ff   <= sn1;
         sp2_ff  <= '0;
         sel_ff  <= 1'b0;
         step_ff <= CW'(2);
         n_ff    <= '0;
         k_ff    <= '0;
         acn_ff  <= '0;
         cs_tab_ff[0]         <= to_q16(ONE_V);
         sn_tab_ff[0]         <= '0;
         cs_tab_ff[ORD_W'(1)] <= to_q16(cos1);
         sn_tab_ff[ORD_W'(1)] <= to_q16(sn1);
      end
      if (state_ff == ahg_pkg::ST_MUL) begin
         prod_ff <= signed'({mul_raw, 1'b0});
      end
      if (state_ff == ahg_pkg::ST_ACC) begin
         sel_ff <= !sel_ff;
         if (sel_ff) begin
            sp2_ff              <= sp_ff;
            sp_ff               <= acc_v;
            sn_tab_ff[step_idx] <= to_q16(acc_v);
            step_ff             <= step_ff + 1'b1;
         end else begin
            cp2_ff              <= cp_ff;
            cp_ff               <= acc_v;
            cs_tab_ff[step_idx] <= to_q16(acc_v);
         end
      end
      if (emit_load) begin
         rsp_value_ff <= em_value;
         rsp_acn_ff   <= acn_ff;
         rsp_last_ff  <= em_last;
         acn_ff       <= acn_ff + 1'b1;
         if (k_end) begin
            n_ff <= n_ff + 1'b1;
            k_ff <= '0;
         end else begin
            k_ff <= k_ff + 1'b1;
         end
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.harmonic_value = rsp_value_ff;
   assign rsp.acn_index      = rsp_acn_ff;
   assign rsp.last           = rsp_last_ff;

endmodule

>>> rtl/azimuth_harmonic_acn_generator_unit.sv
// Azimuth harmonic generator: cos(m*phi) / -sin(m*phi) per ACN index for one angle
// Flow: each angle passes a 31-step iterative CORDIC, then the recursion terms up to the order
//   (cosine then sine, each through a multiply and an accumulate state on one multiplier).
// Throughput: a new angle is taken only after the last value of the one before; one value a cycle
//   while the output is taken; a two-entry queue holds angles that arrive meanwhile.
// Reset: order register returns to 1, queue empties, no value is pending.
module azimuth_harmonic_acn_generator_unit #(
   parameter int MAX_ORDER = 7,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ahg_req_if.sink     req_ch,
   ahg_rsp_if.source   rsp_ch,
   ahg_csr_if.sink     csr_ch
);

   logic [ahg_pkg::ORD_REG_W-1:0] order_ff;
   logic                          push_valid, push_ready;
   logic                          pop_valid, pop_ready;
   ahg_pkg::ahg_job_type          push_data, pop_data;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ahg_pkg::ORDER_RESET;
      end else if (csr_ch.valid) begin
         order_ff <= csr_ch.order;
      end
   end

   ahg_front #(
      .MAX_ORDER (MAX_ORDER)
   ) u_front (
      .req        (req_ch),
      .order_val  (order_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ahg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ahg_back #(
      .MAX_ORDER (MAX_ORDER),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_ch)
   );

endmodule

>>> rtl/ahg_checker.sv
// Port-level checker for the azimuth harmonic generator, bound to the top level
`include "azimuth_harmonic_acn_generator_unit_macros.svh"

module ahg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [ahg_pkg::VAL_W-1:0]    rsp_value,
   input logic [ahg_pkg::ACN_W-1:0]           rsp_acn,
   input logic                                rsp_last
);

   logic [ahg_pkg::ACN_W-1:0] expect_acn_ff, expect_acn_in;

   // ACN restarts at zero after each last transfer
   always_comb begin
      expect_acn_in = expect_acn_ff;
      if (rsp_valid && rsp_ready) begin
         expect_acn_in = rsp_last ? '0 : expect_acn_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_acn_ff <= '0;
      end else begin
         expect_acn_ff <= expect_acn_in;
      end
   end

   `AHG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_acn) && $stable(rsp_last), "response changed while stalled")
   `AHG_ASSERT_IMPL(a_acn_seq, clock, reset, rsp_valid, rsp_acn == expect_acn_ff, "acn index out of sequence")
   `AHG_ASSERT_IMPL(a_last_square, clock, reset, rsp_valid && rsp_last, rsp_acn == 6'd0 || rsp_acn == 6'd3 || rsp_acn == 6'd8 || rsp_acn == 6'd15 || rsp_acn == 6'd24 || rsp_acn == 6'd35 || rsp_acn == 6'd48 || rsp_acn == 6'd63, "last flag not at end of a full order")
   `AHG_ASSERT_IMPL(a_acn_zero, clock, reset, rsp_valid && rsp_acn == 6'd0, rsp_value == 18'sd65536, "acn zero is not unity")
   `AHG_ASSERT_IMPL(a_value_range, clock, reset, rsp_valid, rsp_value <= 18'sd65536 && rsp_value >= -18'sd65536, "harmonic value outside unit range")

endmodule

bind azimuth_harmonic_acn_generator_unit ahg_checker u_ahg_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_value (rsp_ch.harmonic_value),
   .rsp_acn   (rsp_ch.acn_index),
   .rsp_last  (rsp_ch.last)
);
